// ===== design/ipatp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipatp_pkg;

    localparam int CH_W       = 8;
    localparam int GROUP_W    = 16;
    localparam int NUM_GROUPS = 8;
    localparam int COUNT_W    = 4;
    localparam int IDX_W      = 3;
    localparam int OCTETS_W   = 32;
    localparam int HALF_W     = 64;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;

    typedef enum logic [1:0] {
        HEX_START = 2'd0,
        HEX_SEP   = 2'd1,
        HEX_GROUP = 2'd2
    } hex_phase_t;

    // per-word control from the input stage to both readings
    typedef struct packed {
        logic            step;
        logic            finish;
        logic [CH_W-1:0] ch;
    } char_ctl_t;

    typedef struct packed {
        logic                dot_seen;
        logic                ok;
        logic [OCTETS_W-1:0] octets;
    } quad_res_t;

    typedef struct packed {
        logic              ok;
        logic [HALF_W-1:0] high;
        logic [HALF_W-1:0] low;
    } hex_res_t;

endpackage

`default_nettype wire

// ===== design/ipatp_quad.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipatp_quad
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ipatp_pkg::char_ctl_t ctl,
    output ipatp_pkg::quad_res_t      res
);

    logic                           dot_reg, dot_next;
    logic [1:0]                     idx_reg, idx_next;
    logic [7:0]                     acc_reg, acc_next;
    logic [ipatp_pkg::OCTETS_W-1:0] oct_reg, oct_next;
    logic                           err_reg, err_next;
    logic                           tail_reg, tail_next;

    logic       digit;
    logic [7:0] dval;
    logic [7:0] acc_dec;

    assign digit   = (ctl.ch >= ipatp_pkg::CH_ZERO) && (ctl.ch <= ipatp_pkg::CH_NINE);
    assign dval    = ctl.ch - ipatp_pkg::CH_ZERO;
    assign acc_dec = {acc_reg[4:0], 3'b000} + {acc_reg[6:0], 1'b0} + dval;

    always_comb
    begin
        dot_next  = dot_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        oct_next  = oct_reg;
        err_next  = err_reg;
        tail_next = tail_reg;
        if (ctl.step)
        begin
            if (ctl.ch == ipatp_pkg::CH_DOT)
            begin
                dot_next = 1'b1;
            end
            if (!err_reg)
            begin
                if (idx_reg != 2'd3)
                begin
                    if (digit)
                    begin
                        acc_next = acc_dec;
                    end
                    else if (ctl.ch == ipatp_pkg::CH_DOT)
                    begin
                        case (idx_reg)
                            2'd0:    oct_next[31:24] = acc_reg;
                            2'd1:    oct_next[23:16] = acc_reg;
                            2'd2:    oct_next[15:8]  = acc_reg;
                            default: oct_next        = oct_reg;
                        endcase
                        idx_next = idx_reg + 2'd1;
                        acc_next = 8'd0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (!tail_reg)
                begin
                    if (digit)
                    begin
                        acc_next = acc_dec;
                    end
                    else
                    begin
                        tail_next = 1'b1;
                    end
                end
            end
        end
        if (ctl.finish)
        begin
            dot_next  = 1'b0;
            idx_next  = 2'd0;
            acc_next  = 8'd0;
            oct_next  = '0;
            err_next  = 1'b0;
            tail_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= 1'b0;
            idx_reg  <= 2'd0;
            acc_reg  <= 8'd0;
            oct_reg  <= '0;
            err_reg  <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            dot_reg  <= dot_next;
            idx_reg  <= idx_next;
            acc_reg  <= acc_next;
            oct_reg  <= oct_next;
            err_reg  <= err_next;
            tail_reg <= tail_next;
        end
    end

    assign res.dot_seen = dot_reg;
    assign res.ok       = !err_reg && (idx_reg == 2'd3);
    assign res.octets   = oct_reg | {24'd0, acc_reg};

endmodule

`default_nettype wire

// ===== design/ipatp_hex.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipatp_hex
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ipatp_pkg::char_ctl_t ctl,
    output ipatp_pkg::hex_res_t       res
);

    ipatp_pkg::hex_phase_t         phase_reg, phase_next;
    logic [ipatp_pkg::GROUP_W-1:0] acc_reg, acc_next;
    logic [ipatp_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                          err_reg, err_next;
    logic [ipatp_pkg::GROUP_W-1:0] grp_reg  [ipatp_pkg::NUM_GROUPS];
    logic [ipatp_pkg::GROUP_W-1:0] grp_next [ipatp_pkg::NUM_GROUPS];

    logic                          is_hex;
    logic [3:0]                    hval;
    logic                          push;
    logic [ipatp_pkg::GROUP_W-1:0] push_val;
    logic                          full;
    logic                          fin_push;
    logic                          fin_err;
    logic [ipatp_pkg::GROUP_W-1:0] out_grp [ipatp_pkg::NUM_GROUPS];

    always_comb
    begin
        is_hex = 1'b1;
        hval   = 4'd0;
        if ((ctl.ch >= ipatp_pkg::CH_ZERO) && (ctl.ch <= ipatp_pkg::CH_NINE))
        begin
            hval = 4'(ctl.ch - ipatp_pkg::CH_ZERO);
        end
        else if ((ctl.ch >= ipatp_pkg::CH_LA) && (ctl.ch <= ipatp_pkg::CH_LF))
        begin
            hval = 4'(ctl.ch - ipatp_pkg::CH_LA + 8'd10);
        end
        else if ((ctl.ch >= ipatp_pkg::CH_UA) && (ctl.ch <= ipatp_pkg::CH_UF))
        begin
            hval = 4'(ctl.ch - ipatp_pkg::CH_UA + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign full = cnt_reg >= ipatp_pkg::COUNT_W'(ipatp_pkg::NUM_GROUPS);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        grp_next   = grp_reg;
        push       = 1'b0;
        push_val   = acc_reg;
        if (ctl.step && !err_reg)
        begin
            if (is_hex)
            begin
                if (phase_reg != ipatp_pkg::HEX_GROUP)
                begin
                    acc_next = {12'd0, hval};
                end
                else
                begin
                    acc_next = {acc_reg[11:0], hval};
                end
                phase_next = ipatp_pkg::HEX_GROUP;
            end
            else if (ctl.ch == ipatp_pkg::CH_COLON)
            begin
                case (phase_reg)
                    ipatp_pkg::HEX_SEP:
                    begin
                        push     = 1'b1;
                        push_val = '0;
                    end
                    ipatp_pkg::HEX_GROUP:
                    begin
                        push     = 1'b1;
                        push_val = acc_reg;
                        acc_next = '0;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
                phase_next = ipatp_pkg::HEX_SEP;
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        if (push)
        begin
            if (full)
            begin
                err_next = 1'b1;
            end
            else
            begin
                grp_next[cnt_reg[ipatp_pkg::IDX_W-1:0]] = push_val;
                cnt_next = cnt_reg + ipatp_pkg::COUNT_W'(1);
            end
        end
        if (ctl.finish)
        begin
            phase_next = ipatp_pkg::HEX_START;
            acc_next   = '0;
            cnt_next   = '0;
            err_next   = 1'b0;
            for (int i = 0; i < ipatp_pkg::NUM_GROUPS; i++)
            begin
                grp_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ipatp_pkg::HEX_START;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
            for (int i = 0; i < ipatp_pkg::NUM_GROUPS; i++)
            begin
                grp_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            grp_reg   <= grp_next;
        end
    end

    // closing push of an unfinished group at end of string
    assign fin_push = !err_reg && (phase_reg == ipatp_pkg::HEX_GROUP);
    assign fin_err  = err_reg || (fin_push && full);

    always_comb
    begin
        for (int i = 0; i < ipatp_pkg::NUM_GROUPS; i++)
        begin
            if (fin_push && (cnt_reg == ipatp_pkg::COUNT_W'(i)))
            begin
                out_grp[i] = acc_reg;
            end
            else
            begin
                out_grp[i] = grp_reg[i];
            end
        end
    end

    assign res.ok   = !fin_err;
    assign res.high = {out_grp[0], out_grp[1], out_grp[2], out_grp[3]};
    assign res.low  = {out_grp[4], out_grp[5], out_grp[6], out_grp[7]};

endmodule

`default_nettype wire

// ===== design/ip_address_text_parser.sv =====
// a string's result word is registered as its terminating nul word leaves the input stage
// throughput: one character word per cycle; a nul word waits while a result is unaccepted
// output register lets the next string's characters enter while a result waits
// reset: rst_n asynchronous active low, clears both readings, input and output stages
`timescale 1ns / 1ps
`default_nettype none

module ip_address_text_parser
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // ch
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata,   // valid_res, address_high, address_low, zero fill
    output logic              m_axis_tuser    // is_ipv6
);

    logic                            in_valid_reg, in_valid_next;
    logic [ipatp_pkg::CH_W-1:0]      ch_reg;
    logic                            advance;
    logic                            is_nul;
    ipatp_pkg::char_ctl_t            ctl;
    ipatp_pkg::quad_res_t            quad_res;
    ipatp_pkg::hex_res_t             hex_res;

    logic                            out_valid_reg, out_valid_next;
    logic                            ok_reg, ok_next;
    logic                            v6_reg, v6_next;
    logic [ipatp_pkg::HALF_W-1:0]    hi_reg, hi_next;
    logic [ipatp_pkg::HALF_W-1:0]    lo_reg, lo_next;

    assign is_nul        = ch_reg == ipatp_pkg::CH_NUL;
    assign advance       = in_valid_reg && (!is_nul || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    assign ctl.step   = advance && !is_nul;
    assign ctl.finish = advance && is_nul;
    assign ctl.ch     = ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            ch_reg <= s_axis_tdata;
        end
    end

    ipatp_quad u_quad
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .res   (quad_res)
    );

    ipatp_hex u_hex
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .res   (hex_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        ok_next        = ok_reg;
        v6_next        = v6_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
            if (quad_res.dot_seen)
            begin
                ok_next = quad_res.ok;
                v6_next = 1'b0;
                hi_next = quad_res.ok ? {quad_res.octets, 32'd0} : '0;
                lo_next = '0;
            end
            else
            begin
                ok_next = hex_res.ok;
                v6_next = 1'b1;
                hi_next = hex_res.ok ? hex_res.high : '0;
                lo_next = hex_res.ok ? hex_res.low : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        v6_reg <= v6_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, lo_reg, hi_reg, ok_reg};
    assign m_axis_tuser  = v6_reg;

endmodule

`default_nettype wire
